// ----- rtl/yhist_pkg.sv -----
`timescale 1ns / 1ps

package yhist_pkg;

    // Block geometry. A block is BLOCK rows tall; a row carries at most ROW_BITS columns.
    localparam int BLOCK    = 16;
    localparam int ROW_BITS = 16;
    localparam int COLS     = (BLOCK < ROW_BITS) ? BLOCK : ROW_BITS;
    localparam int RS_W     = $clog2(BLOCK);

    // Histogram geometry.
    localparam int NUM_CLS  = 6;
    localparam int CNT_W    = 9;
    localparam int ROWC_W   = $clog2(COLS + 1);
    localparam int PAIRC_W  = $clog2(2 * COLS + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [ROW_BITS-1:0] t_row;
    typedef logic [2:0]          t_cls;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [ROWC_W-1:0]   t_rowc;
    typedef logic [PAIRC_W-1:0]  t_pairc;
    typedef logic [RS_W-1:0]     t_rows_seen;

    typedef t_count [NUM_CLS-1:0] t_hist;
    typedef t_rowc  [NUM_CLS-1:0] t_row_counts;
    typedef t_pairc [NUM_CLS-1:0] t_pair_counts;

    localparam t_cls CLS_ISOLATED   = 3'd0;
    localparam t_cls CLS_END        = 3'd1;
    localparam t_cls CLS_CONNECTING = 3'd2;
    localparam t_cls CLS_BRANCHING  = 3'd3;
    localparam t_cls CLS_CROSSING   = 3'd4;
    localparam t_cls CLS_INTERIOR   = 3'd5;

    // Stage 2 status handed to the histogram unit.
    typedef struct packed {
        logic valid;
        logic last;
    } t_s2_ctrl;

    // 4-connected Yokoi number of a white center pixel.
    // x1 right, x2 up, x3 left, x4 down, x5 down-right, x6 up-right,
    // x7 up-left, x8 down-left.
    function automatic t_cls yokoi_class(
        input logic x1, input logic x2, input logic x3, input logic x4,
        input logic x5, input logic x6, input logic x7, input logic x8
    );
        logic [3:0] q;
        logic [3:0] r;
        t_cls       n_q;
        r[0] = x1 & x6 & x2;
        r[1] = x2 & x7 & x3;
        r[2] = x3 & x8 & x4;
        r[3] = x4 & x5 & x1;
        q[0] = x1 & ~r[0];
        q[1] = x2 & ~r[1];
        q[2] = x3 & ~r[2];
        q[3] = x4 & ~r[3];
        n_q = t_cls'($countones(q));
        if (&r) begin
            return CLS_INTERIOR;
        end
        return n_q;
    endfunction

endpackage

// ----- rtl/yhist_if.sv -----
`timescale 1ns / 1ps

interface yhist_row_if;
    logic                       valid;
    logic                       ready;
    logic [yhist_pkg::ROW_BITS-1:0] row_pixels;

    modport source (output valid, output row_pixels, input ready);
    modport sink   (input valid, input row_pixels, output ready);
endinterface

interface yhist_hist_if;
    logic                        valid;
    logic                        ready;
    logic [yhist_pkg::CNT_W-1:0] count_isolated;
    logic [yhist_pkg::CNT_W-1:0] count_end;
    logic [yhist_pkg::CNT_W-1:0] count_connecting;
    logic [yhist_pkg::CNT_W-1:0] count_branching;
    logic [yhist_pkg::CNT_W-1:0] count_crossing;
    logic [yhist_pkg::CNT_W-1:0] count_interior;

    modport source (
        output valid, output count_isolated, output count_end, output count_connecting,
        output count_branching, output count_crossing, output count_interior,
        input ready
    );
    modport sink (
        input valid, input count_isolated, input count_end, input count_connecting,
        input count_branching, input count_crossing, input count_interior,
        output ready
    );
endinterface

// ----- rtl/yhist_rowcls.sv -----
`timescale 1ns / 1ps

// Classifies every column of one row in parallel and counts the white pixels of each class.
module yhist_rowcls (
    input  yhist_pkg::t_row        i_above,
    input  yhist_pkg::t_row        i_center,
    input  yhist_pkg::t_row        i_below,
    output yhist_pkg::t_row_counts o_counts
);
    import yhist_pkg::*;

    // One black column of padding on each side.
    logic [COLS+1:0]          up_p;
    logic [COLS+1:0]          mid_p;
    logic [COLS+1:0]          dn_p;
    t_cls [COLS-1:0]          col_cls;
    logic [NUM_CLS-1:0][COLS-1:0] hit;

    assign up_p  = {1'b0, i_above[COLS-1:0],  1'b0};
    assign mid_p = {1'b0, i_center[COLS-1:0], 1'b0};
    assign dn_p  = {1'b0, i_below[COLS-1:0],  1'b0};

    always_comb begin
        for (int k = 0; k < COLS; k++) begin
            col_cls[k] = yokoi_class(mid_p[k+2], up_p[k+1], mid_p[k], dn_p[k+1],
                                     dn_p[k+2], up_p[k+2], up_p[k], dn_p[k]);
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CLS; c++) begin
            for (int k = 0; k < COLS; k++) begin
                hit[c][k] = mid_p[k+1] && (col_cls[k] == t_cls'(c));
            end
            o_counts[c] = t_rowc'($countones(hit[c]));
        end
    end

endmodule

// ----- rtl/yhist_accum.sv -----
`timescale 1ns / 1ps

// Saturating six-bin histogram with the result register behind it.
module yhist_accum (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  yhist_pkg::t_s2_ctrl     i_ctrl,
    input  yhist_pkg::t_pair_counts i_counts,
    output logic                    o_advance,
    yhist_hist_if.source            o_hist
);
    import yhist_pkg::*;

    t_hist            r_hist;
    t_hist            n_hist;
    t_hist            r_out;
    t_hist            n_out;
    logic             r_out_valid;
    logic             n_out_valid;
    t_hist            sum;
    logic [CNT_W:0]   wide;
    logic             load;

    // The pipeline only waits when a block ends while the previous result is still unread.
    assign o_advance = !(i_ctrl.valid && i_ctrl.last && r_out_valid && !o_hist.ready);
    assign load      = o_advance && i_ctrl.valid && i_ctrl.last;

    always_comb begin
        for (int c = 0; c < NUM_CLS; c++) begin
            wide   = {1'b0, r_hist[c]} + (CNT_W+1)'(i_counts[c]);
            sum[c] = wide[CNT_W] ? CNT_MAX : wide[CNT_W-1:0];
        end
    end

    always_comb begin
        n_hist      = r_hist;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_hist.ready) begin
            n_out_valid = 1'b0;
        end
        if (o_advance && i_ctrl.valid) begin
            if (i_ctrl.last) begin
                n_hist = '0;
            end else begin
                n_hist = sum;
            end
        end
        if (load) begin
            n_out       = sum;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hist      <= n_hist;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_hist.valid            = r_out_valid;
    assign o_hist.count_isolated   = r_out[CLS_ISOLATED];
    assign o_hist.count_end        = r_out[CLS_END];
    assign o_hist.count_connecting = r_out[CLS_CONNECTING];
    assign o_hist.count_branching  = r_out[CLS_BRANCHING];
    assign o_hist.count_crossing   = r_out[CLS_CROSSING];
    assign o_hist.count_interior   = r_out[CLS_INTERIOR];

endmodule

// ----- rtl/yokoi_block_histogram_top.sv -----
`timescale 1ns / 1ps

// Yokoi connectivity histogram of a square binary block, one row request per cycle unless input ready is low.
// Each row is classified across all columns at once, one row after it arrives (the last
// row of a block together with its predecessor), so a new row is taken every clock while input ready is high.
// The histogram of a block becomes valid after its last row has passed the window register,
// the class count register and the result register, in that order. Input ready drops only
// when a block ends while the previous histogram is still waiting in the result register.
// Pixels outside the block read as black; bins saturate at 511.
module yokoi_block_histogram_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yhist_row_if.sink     i_row,
    yhist_hist_if.source  o_hist
);
    import yhist_pkg::*;

    t_row         col_mask;
    t_row         x;
    logic         advance;
    logic         accept;
    logic         is_last;

    t_row         r_upper;
    t_row         r_middle;
    t_rows_seen   r_rows_seen;

    // Stage 1: two classification windows.
    logic         r_s1_valid;
    logic         r_s1_last;
    t_row         r_s1_a_up;
    t_row         r_s1_a_mid;
    t_row         r_s1_a_dn;
    t_row         r_s1_b_up;
    t_row         r_s1_b_mid;

    // Stage 2: per-class counts of the stage 1 windows.
    t_s2_ctrl     r_s2_ctrl;
    t_pair_counts r_s2_counts;
    t_pair_counts n_s2_counts;

    t_row_counts  counts_a;
    t_row_counts  counts_b;

    assign col_mask    = t_row'((ROW_BITS+1)'(1) << COLS) - t_row'(1);
    assign x           = i_row.row_pixels & col_mask;
    assign i_row.ready = advance;
    assign accept      = i_row.valid && advance;
    assign is_last     = (r_rows_seen == RS_W'(BLOCK - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper     <= '0;
            r_middle    <= '0;
            r_rows_seen <= '0;
        end else if (accept) begin
            if (is_last) begin
                r_upper     <= '0;
                r_middle    <= '0;
                r_rows_seen <= '0;
            end else begin
                r_upper     <= r_middle;
                r_middle    <= x;
                r_rows_seen <= r_rows_seen + RS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
        end
        // The middle row is all black before the first row of a block, which yields no counts.
        if (accept) begin
            r_s1_last  <= is_last;
            r_s1_a_up  <= r_upper;
            r_s1_a_mid <= r_middle;
            r_s1_a_dn  <= x;
            r_s1_b_up  <= r_middle;
            r_s1_b_mid <= is_last ? x : '0;
        end
    end

    yhist_rowcls u_rowcls_a (
        .i_above  (r_s1_a_up),
        .i_center (r_s1_a_mid),
        .i_below  (r_s1_a_dn),
        .o_counts (counts_a)
    );

    yhist_rowcls u_rowcls_b (
        .i_above  (r_s1_b_up),
        .i_center (r_s1_b_mid),
        .i_below  ('0),
        .o_counts (counts_b)
    );

    always_comb begin
        for (int c = 0; c < NUM_CLS; c++) begin
            n_s2_counts[c] = PAIRC_W'(counts_a[c]) + PAIRC_W'(counts_b[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctrl <= '0;
        end else if (advance) begin
            r_s2_ctrl.valid <= r_s1_valid;
            r_s2_ctrl.last  <= r_s1_last;
        end
        if (advance && r_s1_valid) begin
            r_s2_counts <= n_s2_counts;
        end
    end

    yhist_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (r_s2_ctrl),
        .i_counts  (r_s2_counts),
        .o_advance (advance),
        .o_hist    (o_hist)
    );

endmodule
